@@ hdl/lazy_greedy_heap_selector_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the lazy greedy heap selector
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LAZY_GREEDY_HEAP_SELECTOR_ASSERT_SVH
`define LAZY_GREEDY_HEAP_SELECTOR_ASSERT_SVH

// same-cycle implication
`define LGHS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lghs assertion failed");

// next-cycle implication
`define LGHS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lghs assertion failed");

`endif

@@ hdl/lghs_pkg.sv @@
// ---------------------------------------------------------------------------
// lghs_pkg
// Types, codes and helpers shared by the heap selector modules.
// ---------------------------------------------------------------------------
package lghs_pkg;

  localparam int KIND_W   = 2;
  localparam int NODE_W   = 10;
  localparam int ROUND_W  = 11;
  localparam int GAIN_W   = 34;
  localparam int SPREAD_W = 32;
  localparam int CFG_W    = 11;
  localparam int FRAC_W   = 16;

  localparam logic [KIND_W-1:0] KIND_EVAL     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SELECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd3;

  localparam logic REQ_START  = 1'b0;

  localparam logic CFG_NODE_COUNT   = 1'b0;
  localparam logic CFG_SELECT_COUNT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BAD, ST_CLR, ST_START_EMIT, ST_R0, ST_R1,
    ST_L1, ST_L2, ST_L3, ST_L4, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
    ST_F0, ST_F1
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_LOAD, OP_CLR, OP_RD_ROOT, OP_EVAL,
    OP_L1, OP_L2, OP_L3, OP_L4, OP_CHECK, OP_SELECT, OP_REPL,
    OP_REPL_GAIN, OP_NEXT_ROUND
  } op_e;

  typedef enum logic [2:0] {
    EM_NONE, EM_START, EM_BAD, EM_REQ_ROOT, EM_SEL, EM_REQ_HEAP, EM_DONE
  } emit_e;

  typedef struct packed {
    op_e   op;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic has_child;
    logic swap;
    logic fresh;
    logic finish;
    logic out_free;
  } status_t;

  function automatic logic signed [GAIN_W-1:0] sat34(input logic signed [GAIN_W+1:0] v);
    logic signed [GAIN_W+1:0] hi;
    logic signed [GAIN_W+1:0] lo;
    hi = {3'b000, {(GAIN_W-1){1'b1}}};
    lo = {3'b111, {(GAIN_W-1){1'b0}}};
    if (v > hi) begin
      return hi[GAIN_W-1:0];
    end else if (v < lo) begin
      return lo[GAIN_W-1:0];
    end
    return v[GAIN_W-1:0];
  endfunction

endpackage

@@ hdl/lghs_ram.sv @@
// ---------------------------------------------------------------------------
// lghs_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lghs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/lghs_ctrl.sv @@
// ---------------------------------------------------------------------------
// lghs_ctrl
// Sequencer for start, evaluation, sift-down and selection steps.
// ---------------------------------------------------------------------------
module lghs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_req_type_i,
  output logic             in_stall_o,
  input  lghs_pkg::status_t sts_i,
  output lghs_pkg::cmd_t    cmd_o
);
  import lghs_pkg::*;

  state_e state_q, state_d;
  logic   await_q, await_d;
  logic   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      await_q <= 1'b0;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      await_q <= await_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == REQ_START) state_d = ST_CLR;
          else if (await_q) state_d = ST_R0;
          else state_d = ST_BAD;
        end
      end
      ST_BAD:        if (sts_i.out_free) state_d = ST_IDLE;
      ST_CLR:        if (sts_i.clr_last) state_d = ST_START_EMIT;
      ST_START_EMIT: if (sts_i.out_free) state_d = ST_IDLE;
      ST_R0:         state_d = ST_R1;
      ST_R1:         state_d = ST_L1;
      ST_L1: begin
        if (sts_i.has_child) state_d = ST_L2;
        else state_d = ret_q ? ST_F0 : ST_P0;
      end
      ST_L2:         state_d = ST_L3;
      ST_L3:         state_d = ST_L4;
      ST_L4: begin
        if (sts_i.swap) state_d = ST_L1;
        else state_d = ret_q ? ST_F0 : ST_P0;
      end
      ST_P0:         state_d = ST_P1;
      ST_P1:         state_d = ST_P2;
      ST_P2: begin
        if (sts_i.out_free) state_d = sts_i.fresh ? ST_P3 : ST_IDLE;
      end
      ST_P3:         state_d = ST_P4;
      ST_P4:         state_d = ST_L1;
      ST_F0:         state_d = ST_F1;
      ST_F1:         if (sts_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.emit = EM_NONE;
    await_d    = await_q;
    ret_d      = ret_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == REQ_START) cmd_o.op = OP_START;
          else if (await_q) cmd_o.op = OP_LOAD;
        end
      end
      ST_BAD: if (sts_i.out_free) cmd_o.emit = EM_BAD;
      ST_CLR: cmd_o.op = OP_CLR;
      ST_START_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_START;
          await_d    = 1'b1;
        end
      end
      ST_R0: cmd_o.op = OP_RD_ROOT;
      ST_R1: begin
        cmd_o.op = OP_EVAL;
        ret_d    = 1'b0;
      end
      ST_L1: cmd_o.op = OP_L1;
      ST_L2: cmd_o.op = OP_L2;
      ST_L3: cmd_o.op = OP_L3;
      ST_L4: cmd_o.op = OP_L4;
      ST_P0: cmd_o.op = OP_RD_ROOT;
      ST_P1: cmd_o.op = OP_CHECK;
      ST_P2: begin
        if (sts_i.out_free) begin
          if (sts_i.fresh) begin
            cmd_o.op   = OP_SELECT;
            cmd_o.emit = EM_SEL;
          end else begin
            cmd_o.emit = EM_REQ_ROOT;
          end
        end
      end
      ST_P3: cmd_o.op = OP_REPL;
      ST_P4: begin
        cmd_o.op = OP_REPL_GAIN;
        ret_d    = 1'b1;
      end
      ST_F0: cmd_o.op = OP_NEXT_ROUND;
      ST_F1: begin
        if (sts_i.out_free) begin
          if (sts_i.finish) begin
            cmd_o.emit = EM_DONE;
            await_d    = 1'b0;
          end else begin
            cmd_o.emit = EM_REQ_HEAP;
          end
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end
endmodule

@@ hdl/lghs_dp.sv @@
// ---------------------------------------------------------------------------
// lghs_dp
// Heap, gain and stamp memories, sift datapath, sums and result register.
// ---------------------------------------------------------------------------
module lghs_dp #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [lghs_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [lghs_pkg::SPREAD_W-1:0]        in_spread_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [lghs_pkg::KIND_W-1:0]          out_kind_o,
  output logic [lghs_pkg::NODE_W-1:0]          out_node_o,
  output logic [lghs_pkg::ROUND_W-1:0]         out_round_o,
  output logic signed [lghs_pkg::GAIN_W-1:0]   out_gain_o,
  output logic                                 out_last_o,
  input  lghs_pkg::cmd_t                       cmd_i,
  output lghs_pkg::status_t                    sts_o
);
  import lghs_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int CW = IW + 2;

  logic [CFG_W-1:0] node_count_q, select_count_q;

  logic [SPREAD_W-1:0]      spread_q;
  logic signed [GAIN_W-1:0] sum_q, gx_q, g1_q;
  logic [SW-1:0]            r_q, size_q;
  logic [IW-1:0]            idx_q, x_q, vx_q, id1_q, id2_q, root_q;

  logic                     out_valid_q;
  logic [KIND_W-1:0]        kind_q;
  logic [NODE_W-1:0]        node_q;
  logic [ROUND_W-1:0]       round_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic                     last_q;

  logic            h_we, h_re, g_we, g_re, s_we, s_re;
  logic [IW-1:0]   h_waddr, h_raddr, h_wdata, g_waddr, g_raddr, s_waddr, s_raddr;
  logic [IW-1:0]   h_rdata;
  logic [GAIN_W-1:0] g_wdata, g_rdata;
  logic [SW-1:0]   s_wdata, s_rdata;

  lghs_ram #(.Width(IW), .Depth(MAX_NODES)) u_heap (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(h_re), .raddr_i(h_raddr), .rdata_o(h_rdata)
  );
  lghs_ram #(.Width(GAIN_W), .Depth(MAX_NODES)) u_gain (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(g_re), .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  lghs_ram #(.Width(SW), .Depth(MAX_NODES)) u_stamp (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // effective counts
  logic [SW-1:0]            n_eff;
  logic [SW:0]              n_plus;
  logic [GAIN_W-1:0]        gain_init;
  logic [31:0]              k_eff, total;
  logic [SW-1:0]            r_next;
  logic signed [GAIN_W-1:0] g_eval, g_sel, g2, gc;
  logic [CW-1:0]            c1, c2, size_c;
  logic                     c2_ok, pick2, swap;
  logic [IW-1:0]            idc, cidx;

  always_comb begin
    if (node_count_q == '0) n_eff = SW'(1);
    else if (32'(node_count_q) > 32'(MAX_NODES)) n_eff = SW'(MAX_NODES);
    else n_eff = SW'(node_count_q);
    n_plus    = (SW+1)'(n_eff) + (SW+1)'(1);
    gain_init = GAIN_W'({n_plus, {FRAC_W{1'b0}}});

    total = 32'(size_q) + 32'(r_q);
    k_eff = (select_count_q == '0) ? 32'd1 : 32'(select_count_q);
    if (k_eff > total) k_eff = total;

    r_next = r_q + SW'(1);
    g_eval = sat34($signed({4'b0000, spread_q}) - (GAIN_W+2)'(sum_q));
    g_sel  = sat34((GAIN_W+2)'(sum_q) + (GAIN_W+2)'($signed(g_rdata)));

    c1     = CW'({x_q, 1'b1});
    c2     = c1 + CW'(1);
    size_c = CW'(size_q);
    c2_ok  = c2 < size_c;
    g2     = $signed(g_rdata);
    pick2  = c2_ok && (g1_q < g2);
    gc     = pick2 ? g2 : g1_q;
    idc    = pick2 ? id2_q : id1_q;
    cidx   = pick2 ? IW'(c2) : IW'(c1);
    swap   = gx_q < gc;
  end

  assign sts_o.clr_last  = (idx_q == IW'(MAX_NODES - 1));
  assign sts_o.has_child = c1 < size_c;
  assign sts_o.swap      = swap;
  assign sts_o.fresh     = (s_rdata == r_next);
  assign sts_o.finish    = (32'(r_q) >= k_eff) || (size_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // memory port selection
  always_comb begin
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_re = 1'b0; h_raddr = '0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    case (cmd_i.op)
      OP_CLR: begin
        h_we = 1'b1; h_waddr = idx_q; h_wdata = idx_q;
        g_we = 1'b1; g_waddr = idx_q; g_wdata = gain_init;
        s_we = 1'b1; s_waddr = idx_q; s_wdata = '0;
      end
      OP_RD_ROOT, OP_NEXT_ROUND: begin
        h_re = 1'b1;
      end
      OP_EVAL: begin
        g_we = 1'b1; g_waddr = h_rdata; g_wdata = g_eval;
        s_we = 1'b1; s_waddr = h_rdata; s_wdata = r_next;
      end
      OP_L1: begin
        if (sts_o.has_child) begin
          h_re = 1'b1; h_raddr = IW'(c1);
        end else begin
          h_we = 1'b1; h_waddr = x_q; h_wdata = vx_q;
        end
      end
      OP_L2: begin
        h_re = 1'b1; h_raddr = IW'(c2);
        g_re = 1'b1; g_raddr = h_rdata;
      end
      OP_L3: begin
        g_re = 1'b1; g_raddr = h_rdata;
      end
      OP_L4: begin
        h_we = 1'b1; h_waddr = x_q; h_wdata = swap ? idc : vx_q;
      end
      OP_CHECK: begin
        g_re = 1'b1; g_raddr = h_rdata;
        s_re = 1'b1; s_raddr = h_rdata;
      end
      OP_SELECT: begin
        h_re = 1'b1; h_raddr = IW'(size_q - SW'(1));
      end
      OP_REPL: begin
        g_re = 1'b1; g_raddr = h_rdata;
      end
      default: h_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= CFG_W'(1024);
      select_count_q <= CFG_W'(1);
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_NODE_COUNT) node_count_q <= cfg_data_i;
        else select_count_q <= cfg_data_i;
      end
      if (cmd_i.emit != EM_NONE) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        idx_q <= '0; r_q <= '0; sum_q <= '0; size_q <= n_eff;
      end
      OP_LOAD:   spread_q <= in_spread_i;
      OP_CLR:    idx_q <= idx_q + IW'(1);
      OP_EVAL: begin
        vx_q <= h_rdata; gx_q <= g_eval; x_q <= '0;
      end
      OP_L2:     id1_q <= h_rdata;
      OP_L3: begin
        id2_q <= h_rdata; g1_q <= $signed(g_rdata);
      end
      OP_L4:     if (swap) x_q <= cidx;
      OP_CHECK:  root_q <= h_rdata;
      OP_SELECT: sum_q <= g_sel;
      OP_REPL: begin
        vx_q <= h_rdata; size_q <= size_q - SW'(1);
      end
      OP_REPL_GAIN: begin
        gx_q <= $signed(g_rdata); x_q <= '0;
      end
      OP_NEXT_ROUND: r_q <= r_next;
      default: x_q <= x_q;
    endcase

    case (cmd_i.emit)
      EM_START, EM_REQ_ROOT, EM_REQ_HEAP: begin
        kind_q  <= KIND_EVAL;
        node_q  <= (cmd_i.emit == EM_START) ? '0
                 : NODE_W'((cmd_i.emit == EM_REQ_ROOT) ? root_q : h_rdata);
        round_q <= ROUND_W'(r_next);
        gain_q  <= '0;
        last_q  <= 1'b1;
      end
      EM_SEL: begin
        kind_q  <= KIND_SELECTED;
        node_q  <= NODE_W'(root_q);
        round_q <= ROUND_W'(r_q);
        gain_q  <= $signed(g_rdata);
        last_q  <= 1'b0;
      end
      EM_DONE: begin
        kind_q  <= KIND_DONE;
        node_q  <= '0;
        round_q <= ROUND_W'(r_q);
        gain_q  <= '0;
        last_q  <= 1'b1;
      end
      EM_BAD: begin
        kind_q  <= KIND_IGNORED;
        node_q  <= '0;
        round_q <= '0;
        gain_q  <= '0;
        last_q  <= 1'b1;
      end
      default: last_q <= last_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_node_o  = node_q;
  assign out_round_o = round_q;
  assign out_gain_o  = gain_q;
  assign out_last_o  = last_q;
endmodule

@@ hdl/lazy_greedy_heap_selector.sv @@
// Start: one item in, a clearing pass over all MAX_NODES entries of the
// memories, then the evaluate request. A spread result runs the evaluation
// and up to two sift-downs, each one heap level per loop pass (one heap
// memory port per step). One item at a time.
// Reset clears control state and sets node_count 1024, select_count 1.
// ---------------------------------------------------------------------------
// lazy_greedy_heap_selector
// Lazy greedy (CELF) seed selection over a max-heap of marginal gains.
// ---------------------------------------------------------------------------
module lazy_greedy_heap_selector #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [lghs_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_req_type_i,
  input  logic [lghs_pkg::SPREAD_W-1:0]       in_spread_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lghs_pkg::KIND_W-1:0]         out_kind_o,
  output logic [lghs_pkg::NODE_W-1:0]         out_node_o,
  output logic [lghs_pkg::ROUND_W-1:0]        out_round_o,
  output logic signed [lghs_pkg::GAIN_W-1:0]  out_gain_o,
  output logic                                out_last_o
);
  import lghs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lghs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_req_type_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  lghs_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_spread_i,
    .out_stall_i, .out_valid_o, .out_kind_o, .out_node_o, .out_round_o,
    .out_gain_o, .out_last_o, .cmd_i(cmd), .sts_o(sts)
  );
endmodule

@@ hdl/lghs_checker.sv @@
// ---------------------------------------------------------------------------
// lghs_checker
// Port-level checks on the heap selector, bound to the top level.
// ---------------------------------------------------------------------------
`include "lazy_greedy_heap_selector_assert.svh"

module lghs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic                                cfg_index_i,
  input logic [lghs_pkg::CFG_W-1:0]          cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                in_req_type_i,
  input logic [lghs_pkg::SPREAD_W-1:0]       in_spread_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [lghs_pkg::KIND_W-1:0]         out_kind_o,
  input logic [lghs_pkg::NODE_W-1:0]         out_node_o,
  input logic [lghs_pkg::ROUND_W-1:0]        out_round_o,
  input logic signed [lghs_pkg::GAIN_W-1:0]  out_gain_o,
  input logic                                out_last_o
);
  import lghs_pkg::*;

  logic                                     out_wait;
  logic                                     in_take;
  logic                                     out_quiet_kind;
  logic                                     out_fields_zero;
  logic [KIND_W+NODE_W+ROUND_W+GAIN_W:0]    out_payload;

  assign out_wait        = out_valid_o && out_stall_i;
  assign in_take         = in_valid_i && !in_stall_o;
  assign out_quiet_kind  = (out_kind_o == KIND_DONE) || (out_kind_o == KIND_IGNORED);
  assign out_fields_zero = (out_node_o == '0) && (out_gain_o == '0);
  assign out_payload     = {out_kind_o, out_node_o, out_round_o, out_gain_o, out_last_o};

  `LGHS_ASSERT_NXT(a_out_hold, out_wait, out_valid_o && $stable(out_payload))
  `LGHS_ASSERT_NXT(a_busy_after_item, in_take, in_stall_o)
  `LGHS_ASSERT_IMP(a_last_by_kind, out_valid_o, (out_kind_o == KIND_SELECTED) != out_last_o)
  `LGHS_ASSERT_IMP(a_quiet_fields, out_valid_o && out_quiet_kind, out_fields_zero)
endmodule

bind lazy_greedy_heap_selector lghs_checker u_lghs_checker (.*);

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top - lazy greedy heap selector testbench
// A directed table, then random selection runs with random content. Each
// accepted item is run through a behavioural copy of the selector and the
// outputs are checked in order, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  import lghs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 1024;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [NODE_W-1:0]         node;
    logic [ROUND_W-1:0]        round;
    logic signed [GAIN_W-1:0]  gain;
    logic                      last;
  } res_t;

  typedef struct {
    bit          set_cfg;
    int          cfg_n;
    int          cfg_k;
    logic        req;
    logic [31:0] spread;
    int          n_typed;
    res_t        r0;
    res_t        r1;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = CFG_NODE_COUNT;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic in_req_type_i = REQ_START;
  logic [SPREAD_W-1:0] in_spread_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KIND_W-1:0] out_kind_o;
  logic [NODE_W-1:0] out_node_o;
  logic [ROUND_W-1:0] out_round_o;
  logic signed [GAIN_W-1:0] out_gain_o;
  logic out_last_o;

  lazy_greedy_heap_selector u_top (.*);

  // selector copy
  int          sel_ids[NODES];
  longint      sel_gain[NODES];
  int          sel_stamp[NODES];
  int          sel_round;
  int          sel_size;
  longint      sel_sum;
  bit          sel_busy;
  int          reg_nodes;
  int          reg_select;
  res_t        expected_results[$];

  int  errors;
  bit  hold_off_req;
  int  items_sent;
  bit  quiet;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp_gain(longint v);
    if (v > 64'sd8589934591) return 64'sd8589934591;
    if (v < -64'sd8589934592) return -64'sd8589934592;
    return v;
  endfunction

  function automatic res_t mk(int kind, int node, int round, longint gain, int last);
    res_t r;
    r.kind = KIND_W'(kind);
    r.node = NODE_W'(node);
    r.round = ROUND_W'(round);
    r.gain = GAIN_W'(gain);
    r.last = 1'(last);
    return r;
  endfunction

  function automatic void queue_result(res_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_selection();
    int n;
    n = reg_nodes < 1 ? 1 : (reg_nodes > NODES ? NODES : reg_nodes);
    for (int i = 0; i < NODES; i++) begin
      sel_ids[i] = i;
      sel_gain[i] = longint'(n + 1) * 65536;
      sel_stamp[i] = 0;
    end
    sel_round = 0;
    sel_size = n;
    sel_sum = 0;
    sel_busy = 0;
  endfunction

  function automatic void sift_root(int size);
    int x, c, t;
    x = 0;
    while (2 * x + 1 < size) begin
      c = 2 * x + 1;
      if (c + 1 < size && sel_gain[sel_ids[c]] < sel_gain[sel_ids[c + 1]]) c++;
      if (sel_gain[sel_ids[x]] < sel_gain[sel_ids[c]]) begin
        t = sel_ids[x];
        sel_ids[x] = sel_ids[c];
        sel_ids[c] = t;
        x = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void predict_selection(logic req, logic [31:0] spread);
    int r, root, k;
    if (req == REQ_START) begin
      clear_selection();
      sel_busy = 1;
      queue_result(mk(KIND_EVAL, sel_ids[0], 1, 0, 1));
      return;
    end
    if (!sel_busy) begin
      queue_result(mk(KIND_IGNORED, 0, 0, 0, 1));
      return;
    end
    r = sel_round;
    root = sel_ids[0];
    sel_gain[root] = clamp_gain(longint'(spread) - sel_sum);
    sel_stamp[root] = r + 1;
    sift_root(sel_size);
    root = sel_ids[0];
    if (sel_stamp[root] != r + 1) begin
      queue_result(mk(KIND_EVAL, root, r + 1, 0, 1));
      return;
    end
    queue_result(mk(KIND_SELECTED, root, r, sel_gain[root], 0));
    sel_sum = clamp_gain(sel_sum + sel_gain[root]);
    sel_ids[0] = sel_ids[(sel_size - 1) % NODES];
    sel_size--;
    sift_root(sel_size);
    sel_round = r + 1;
    k = reg_select < 1 ? 1 : reg_select;
    if (k > sel_size + sel_round) k = sel_size + sel_round;
    if (sel_round >= k || sel_size == 0) begin
      sel_busy = 0;
      queue_result(mk(KIND_DONE, 0, sel_round, 0, 1));
    end else begin
      queue_result(mk(KIND_EVAL, sel_ids[0], sel_round + 1, 0, 1));
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d node %0d", $realtime, out_kind_o,
                 out_node_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_kind_o !== e.kind || out_node_o !== e.node || out_round_o !== e.round ||
            out_gain_o !== e.gain || out_last_o !== e.last) begin
          $display("%0t: mismatch expected kind %0d node %0d round %0d gain %0d last %0d",
                   $realtime, e.kind, e.node, e.round, e.gain, e.last);
          $display("%0t:          actual   kind %0d node %0d round %0d gain %0d last %0d",
                   $realtime, out_kind_o, out_node_o, out_round_o, out_gain_o, out_last_o);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int r;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off_req = 0;
      end
      r = $urandom_range(0, 99);
      if (quiet || r < 65) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  // timeout
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 6000000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return;
    in_valid_i <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clk_i);
  endtask

  task automatic send_item(logic req, logic [31:0] spread);
    in_valid_i <= 1'b1;
    in_req_type_i <= req;
    in_spread_i <= spread;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (items_sent == 600) hold_off_req = 1;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(int n, int k);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_NODE_COUNT;
    cfg_data_i <= CFG_W'(n);
    @(posedge clk_i);
    cfg_index_i <= CFG_SELECT_COUNT;
    cfg_data_i <= CFG_W'(k);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_nodes = n;
    reg_select = k;
  endtask

  function automatic logic [31:0] pick_spread();
    longint s;
    int n;
    int r;
    n = sel_size + sel_round;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom;
    if (r < 22) s = sel_sum - $urandom_range(0, 300000);
    else s = sel_sum + longint'($urandom_range(0, (n + 2) * 4)) * 16384 + $urandom_range(0, 65535);
    if (s < 0) s = 0;
    if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
    return s[31:0];
  endfunction

  row_t directed[$];

  function automatic void add_row(row_t w);
    directed.insert(directed.size(), w);
  endfunction

  initial begin
    row_t w;
    int budget, n, k, q_len;
    errors = 0;
    items_sent = 0;
    quiet = 0;
    hold_off_req = 0;
    reg_nodes = 1024;
    reg_select = 1;
    clear_selection();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    add_row('{0, 0, 0, 1'b1, 32'd0, 1, mk(KIND_IGNORED, 0, 0, 0, 1), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, REQ_START, 32'd0, 1, mk(KIND_EVAL, 0, 1, 0, 1), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'd0, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'hFFFFFFFF, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'd5, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{1, 2, 2047, REQ_START, 32'hFFFFFFFF, 1, mk(KIND_EVAL, 0, 1, 0, 1),
              mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'hFFFFFFFF, 2,
              mk(KIND_SELECTED, 0, 0, 64'hFFFFFFFF, 0), mk(KIND_EVAL, 1, 2, 0, 1)});
    add_row('{0, 0, 0, 1'b1, 32'd0, 2,
              mk(KIND_SELECTED, 1, 1, -64'sh0FFFFFFFF, 0), mk(KIND_DONE, 0, 2, 0, 1)});
    add_row('{0, 0, 0, 1'b1, 32'h80000001, 1, mk(KIND_IGNORED, 0, 0, 0, 1),
              mk(0,0,0,0,0)});
    add_row('{1, 0, 0, REQ_START, 32'd0, 1, mk(KIND_EVAL, 0, 1, 0, 1), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'h55555555, 2,
              mk(KIND_SELECTED, 0, 0, 64'h55555555, 0), mk(KIND_DONE, 0, 1, 0, 1)});
    add_row('{1, 3, 3, REQ_START, 32'd0, 1, mk(KIND_EVAL, 0, 1, 0, 1), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'h00010000, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, REQ_START, 32'hAAAAAAAA, 1, mk(KIND_EVAL, 0, 1, 0, 1),
              mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'h00050000, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'h00060000, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});
    add_row('{0, 0, 0, 1'b1, 32'h00070000, 0, mk(0,0,0,0,0), mk(0,0,0,0,0)});

    foreach (directed[i]) begin
      w = directed[i];
      if (w.set_cfg) begin
        drain();
        write_cfg(w.cfg_n, w.cfg_k);
      end
      send_item(w.req, w.spread);
      q_len = expected_results.size();
      predict_selection(w.req, w.spread);
      if (w.n_typed > 0) begin
        while (expected_results.size() > q_len) void'(expected_results.pop_back());
        queue_result(w.r0);
        if (w.n_typed > 1) queue_result(w.r1);
      end
      sender_gap();
    end

    while (items_sent < 1520) begin
      drain();
      case ($urandom_range(0, 9))
        0: begin n = 2047; k = $urandom_range(1, 3); end
        1: begin n = 0; k = $urandom_range(0, 2047); end
        2: begin n = $urandom_range(2, 40); k = 2047; end
        3: begin n = $urandom_range(1, 2047); k = 0; end
        default: begin n = $urandom_range(1, 40); k = $urandom_range(0, n + 3); end
      endcase
      write_cfg(n, k);
      quiet = ($urandom_range(0, 5) == 0);
      budget = $urandom_range(40, 160);
      repeat (budget) begin
        if (!sel_busy) begin
          if ($urandom_range(0, 99) < 85) begin
            send_item(REQ_START, $urandom);
            predict_selection(REQ_START, in_spread_i);
          end else begin
            send_item(1'b1, $urandom);
            predict_selection(1'b1, in_spread_i);
          end
        end else if ($urandom_range(0, 99) < 3) begin
          send_item(REQ_START, $urandom);
          predict_selection(REQ_START, in_spread_i);
        end else begin
          send_item(1'b1, pick_spread());
          predict_selection(1'b1, in_spread_i);
        end
        sender_gap();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lghs_pkg.sv
hdl/lghs_ram.sv
hdl/lghs_ctrl.sv
hdl/lghs_dp.sv
hdl/lazy_greedy_heap_selector.sv
hdl/lghs_checker.sv
test/tb_top.sv
